/* sv/ced_pkg.sv */
// Shared types and constants for the case-insensitive edit distance block.
package ced_pkg;
  localparam int unsigned MaxLen = 64;
  localparam int unsigned LenW = $clog2(MaxLen + 1);
  localparam int unsigned IdxW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned DistW = 7;
  localparam int unsigned CellW = LenW + 1;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_DONE
  } eng_state_e;

  // Command handed from front to back part.
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction
endpackage

/* sv/case_insensitive_edit_distance_top.sv */
// Top level of the case-insensitive edit distance block.
// Usage:
//  Input queue side: drive operation_i/char_code_i with push; an item is taken
//  when push is high and full is low. Operation 0 appends to the first string,
//  1 to the second, 2 computes the distance and clears both strings; 3 is dropped.
//  A four-entry command queue separates intake from the compute engine.
//  Result queue side: while empty is low, distance_o/overflowed_o show the
//  result; pop with empty low takes it.
//  Appends are taken whenever the engine idles. A compute passes through init,
//  one row state per first-string byte and done, one DP row per cycle as 64-bit
//  column delta vectors; no new command is taken until the engine idles again.
//  Reset clears lengths, the overflow flag, the queue and the result slot;
//  no clearing pass is needed.
//  If the receiver stalls, one result is held; a following compute waits and
//  the command queue fills, after which full rises.
module case_insensitive_edit_distance_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                operation_i,
  input  logic [7:0]                char_code_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [ced_pkg::DistW-1:0] distance_o,
  output logic                      overflowed_o
);
  import ced_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;

  ced_front u_front (
    .clk_i, .rst_ni, .push, .full, .operation_i, .char_code_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  ced_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .empty, .pop, .distance_o, .overflowed_o
  );
endmodule

/* sv/ced_front.sv */
// Front part: accepts items, drops unused operations, queues commands.
module ced_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    operation_i,
  input  logic [7:0]    char_code_i,
  output logic          cmd_valid_o,
  output ced_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);
  import ced_pkg::*;

  cmd_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              enq_en, deq_en;

  assign full        = (cnt_q == QCntW'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rptr_q];
  // Unused operation codes never enter the queue.
  assign enq_en = push && !full && (op_e'(operation_i) != OP_NONE);
  assign deq_en = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (enq_en) begin
      mem_q[wptr_q] <= '{op: op_e'(operation_i), ch: char_code_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (enq_en) wptr_q <= wptr_q + 1'b1;
      if (deq_en) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(enq_en) - QCntW'(deq_en);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth)) else $error("queue count overflow");
  a_no_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_en |-> operation_i != OP_NONE) else $error("unused op queued");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enq_en && !deq_en) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance");
endmodule

/* sv/ced_back.sv */
// Back part: string stores, row-per-cycle distance engine and result register.
module ced_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  ced_pkg::cmd_t               cmd_i,
  output logic                        cmd_take_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [ced_pkg::DistW-1:0]   distance_o,
  output logic                        overflowed_o
);
  import ced_pkg::*;

  logic [7:0]        a_q [MaxLen];
  logic [7:0]        b_q [MaxLen];
  logic [MaxLen-1:0] pv_q, mv_q;
  logic [MaxLen-1:0] bmask, btop, eq, d0, hp, hn, hp_s, hn_s;
  logic [CellW-1:0]  score_q, score_d;
  logic [LenW-1:0]   len_a_q, len_b_q, i_q;
  logic              ovf_q;
  eng_state_e        state_q, state_d;
  logic [7:0]        ca_q;
  logic              res_v_q, res_ovf_q;
  logic [DistW-1:0]  res_d_q;
  logic              start, load;

  // Loads are taken any time the engine idles; a run waits for a free result slot.
  assign load  = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op != OP_RUN);
  assign start = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_RUN) &&
                 (!res_v_q || pop);
  assign cmd_take_o = load || start;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_INIT;
      ST_INIT: state_d = (len_a_q == '0) ? ST_DONE : ST_ROW;
      ST_ROW:  if (i_q == len_a_q) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Match vector of the current first-string byte against the second string;
  // positions past its length never match, and btop marks its last position.
  always_comb begin
    for (int j = 0; j < MaxLen; j++) begin
      bmask[j] = (LenW'(j) < len_b_q);
      btop[j]  = (LenW'(j + 1) == len_b_q);
      eq[j]    = bmask[j] && (ca_q == fold_case(b_q[j]));
    end
  end

  // One DP row per cycle as vertical delta vectors (bit-parallel form);
  // the last column value is tracked in score_q.
  assign d0   = (((eq & pv_q) + pv_q) ^ pv_q) | eq | mv_q;
  assign hp   = mv_q | ~(d0 | pv_q);
  assign hn   = d0 & pv_q;
  assign hp_s = {hp[MaxLen-2:0], 1'b1};
  assign hn_s = {hn[MaxLen-2:0], 1'b0};

  always_comb begin
    if ((len_b_q == '0) || (|(hp & btop))) score_d = score_q + 1'b1;
    else if (|(hn & btop)) score_d = score_q - 1'b1;
    else score_d = score_q;
  end

  always_ff @(posedge clk_i) begin
    if (load && cmd_i.op == OP_LOAD_A && len_a_q < LenW'(MaxLen))
      a_q[len_a_q[IdxW-1:0]] <= cmd_i.ch;
    if (load && cmd_i.op == OP_LOAD_B && len_b_q < LenW'(MaxLen))
      b_q[len_b_q[IdxW-1:0]] <= cmd_i.ch;
    if (state_q == ST_INIT) begin
      pv_q    <= '1;
      mv_q    <= '0;
      score_q <= CellW'(len_b_q);
      ca_q    <= fold_case(a_q[0]);
    end else if (state_q == ST_ROW) begin
      pv_q    <= hn_s | ~(d0 | hp_s);
      mv_q    <= hp_s & d0;
      score_q <= score_d;
      if (i_q < LenW'(MaxLen)) ca_q <= fold_case(a_q[i_q[IdxW-1:0]]);
    end
    if (state_q == ST_DONE) begin
      res_d_q   <= (score_q > CellW'(127)) ? DistW'(127) : DistW'(score_q);
      res_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_a_q <= '0;
      len_b_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        if (cmd_i.op == OP_LOAD_A) begin
          if (len_a_q < LenW'(MaxLen)) len_a_q <= len_a_q + 1'b1;
          else ovf_q <= 1'b1;
        end else begin
          if (len_b_q < LenW'(MaxLen)) len_b_q <= len_b_q + 1'b1;
          else ovf_q <= 1'b1;
        end
      end
      if (state_q == ST_INIT) i_q <= LenW'(1);
      else if (state_q == ST_ROW) i_q <= i_q + 1'b1;
      if (state_q == ST_DONE) begin
        len_a_q <= '0;
        len_b_q <= '0;
        ovf_q   <= 1'b0;
        res_v_q <= 1'b1;
      end else if (pop && res_v_q) begin
        res_v_q <= 1'b0;
      end
    end
  end

  assign empty        = !res_v_q;
  assign distance_o   = res_d_q;
  assign overflowed_o = res_ovf_q;

  a_len_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_a_q <= LenW'(MaxLen)) else $error("first length beyond capacity");
  a_len_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_b_q <= LenW'(MaxLen)) else $error("second length beyond capacity");
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> (!res_v_q || pop)) else $error("run started with result slot busy");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> res_v_q && state_q == ST_IDLE)
    else $error("result not posted");
endmodule
